### hdl/msde_pkg.sv
// Shared types, opcode and function codes for the MIPS subset decode/execute block.
// Used by msde_front, msde_queue, msde_back and mips_subset_decode_execute.
// No dependencies.
package msde_pkg;

    // Architectural sizes
    localparam int C_WORD_W     = 32;
    localparam int C_REG_IDX_W  = 5;
    localparam int C_NUM_REGS   = 1 << C_REG_IDX_W;
    localparam int C_SHAMT_W    = 5;
    localparam int C_IMM_W      = 16;

    // Program counter advance per instruction
    localparam logic [C_WORD_W-1:0] C_PC_STEP = 32'd4;

    // Depth of the queue between front and back
    localparam int C_QUEUE_DEPTH = 2;

    // Primary opcodes (bits 31..26)
    localparam logic [5:0] C_OPC_RTYPE = 6'h00;
    localparam logic [5:0] C_OPC_ADDI  = 6'h08;
    localparam logic [5:0] C_OPC_ANDI  = 6'h0C;
    localparam logic [5:0] C_OPC_ORI   = 6'h0D;

    // R-type function codes (bits 5..0)
    localparam logic [5:0] C_FN_SLL = 6'h00;
    localparam logic [5:0] C_FN_SRA = 6'h03;
    localparam logic [5:0] C_FN_ADD = 6'h20;
    localparam logic [5:0] C_FN_SUB = 6'h22;
    localparam logic [5:0] C_FN_AND = 6'h24;
    localparam logic [5:0] C_FN_OR  = 6'h25;
    localparam logic [5:0] C_FN_NOR = 6'h27;

    // Internal ALU operation codes
    typedef logic [2:0] t_op;
    localparam t_op C_OP_SLL = 3'd0;
    localparam t_op C_OP_SRA = 3'd1;
    localparam t_op C_OP_ADD = 3'd2;
    localparam t_op C_OP_SUB = 3'd3;
    localparam t_op C_OP_AND = 3'd4;
    localparam t_op C_OP_OR  = 3'd5;
    localparam t_op C_OP_NOR = 3'd6;
    localparam t_op C_OP_ILL = 3'd7;

    // Decoded request handed from front to back
    typedef struct packed {
        t_op                    op;
        logic                   use_imm;
        logic [C_REG_IDX_W-1:0] rs;
        logic [C_REG_IDX_W-1:0] rt;
        logic [C_REG_IDX_W-1:0] dest;
        logic [C_SHAMT_W-1:0]   shamt;
        logic [C_WORD_W-1:0]    imm;
    } t_uop;

endpackage

### hdl/mips_subset_decode_execute.sv
// Top level of the MIPS integer subset decode/execute block.
// Depends on msde_pkg, msde_front, msde_queue and msde_back.
//
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one 32-bit instruction word
//   per request. Output channel: o_out_valid / i_out_ready carry one result
//   per instruction: next PC, write enable, destination register, written
//   value and an illegal flag (unknown encodings write nothing).
//   Path: a request passes from the queue into the register-file read stage,
//   then executes into the result register.
//   Throughput: one instruction per cycle while the receiver does not stall;
//   the register file read is registered and the write made in the same
//   cycle is forwarded, so dependent instructions follow back to back.
//   Reset (i_rst_n low at a clock edge) empties the queue and pipeline,
//   clears the program counter and marks every register as zero.
//   When the receiver stalls, the result register holds, the read stage
//   holds behind it, and the two-entry queue absorbs requests until full;
//   o_in_ready then drops.
module mips_subset_decode_execute (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [31:0]         i_instruction_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_next_pc,
    output logic                o_write_enable,
    output logic [4:0]          o_dest_register,
    output logic signed [31:0]  o_write_value,
    output logic                o_illegal
);
    import msde_pkg::*;

    logic push, pop, q_full, q_empty;
    t_uop push_uop, head_uop;

    msde_front u_front (
        .i_in_valid         (i_in_valid),
        .i_instruction_word (i_instruction_word),
        .i_queue_full       (q_full),
        .o_in_ready         (o_in_ready),
        .o_push             (push),
        .o_push_uop         (push_uop)
    );

    msde_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_uop (push_uop),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_head     (head_uop)
    );

    msde_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_head          (head_uop),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_next_pc       (o_next_pc),
        .o_write_enable  (o_write_enable),
        .o_dest_register (o_dest_register),
        .o_write_value   (o_write_value),
        .o_illegal       (o_illegal)
    );

endmodule

### hdl/msde_front.sv
// Front end: accepts instruction requests and decodes them into t_uop entries.
// Depends on msde_pkg; feeds msde_queue.
module msde_front (
    input  logic                     i_in_valid,
    input  logic [31:0]              i_instruction_word,
    input  logic                     i_queue_full,
    output logic                     o_in_ready,
    output logic                     o_push,
    output msde_pkg::t_uop           o_push_uop
);
    import msde_pkg::*;

    logic [5:0]         opcode;
    logic [5:0]         funct;
    logic [C_IMM_W-1:0] imm16;

    assign opcode = i_instruction_word[31:26];
    assign funct  = i_instruction_word[5:0];
    assign imm16  = i_instruction_word[C_IMM_W-1:0];

    // Accept whenever the queue has room
    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Classify the instruction and prepare the second operand
    always_comb begin
        o_push_uop.rs      = i_instruction_word[25:21];
        o_push_uop.rt      = i_instruction_word[20:16];
        o_push_uop.shamt   = i_instruction_word[10:6];
        o_push_uop.dest    = i_instruction_word[20:16];
        o_push_uop.use_imm = 1'b1;
        o_push_uop.imm     = {{(C_WORD_W-C_IMM_W){1'b0}}, imm16};
        o_push_uop.op      = C_OP_ILL;
        unique case (opcode)
            C_OPC_RTYPE: begin
                o_push_uop.dest    = i_instruction_word[15:11];
                o_push_uop.use_imm = 1'b0;
                unique case (funct)
                    C_FN_SLL: o_push_uop.op = C_OP_SLL;
                    C_FN_SRA: o_push_uop.op = C_OP_SRA;
                    C_FN_ADD: o_push_uop.op = C_OP_ADD;
                    C_FN_SUB: o_push_uop.op = C_OP_SUB;
                    C_FN_AND: o_push_uop.op = C_OP_AND;
                    C_FN_OR:  o_push_uop.op = C_OP_OR;
                    C_FN_NOR: o_push_uop.op = C_OP_NOR;
                    default:  o_push_uop.op = C_OP_ILL;
                endcase
            end
            C_OPC_ADDI: begin
                o_push_uop.op  = C_OP_ADD;
                o_push_uop.imm = {{(C_WORD_W-C_IMM_W){imm16[C_IMM_W-1]}}, imm16};
            end
            C_OPC_ANDI: o_push_uop.op = C_OP_AND;
            C_OPC_ORI:  o_push_uop.op = C_OP_OR;
            default:    o_push_uop.op = C_OP_ILL;
        endcase
    end

endmodule

### hdl/msde_queue.sv
// Short FIFO of decoded requests between front and back.
// Depends on msde_pkg (t_uop, C_QUEUE_DEPTH).
module msde_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  msde_pkg::t_uop      i_push_uop,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output msde_pkg::t_uop      o_head
);
    import msde_pkg::*;

    localparam int PtrW = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(C_QUEUE_DEPTH + 1);

    t_uop             r_slot [C_QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count,  n_count;

    assign o_full  = (r_count == CntW'(C_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(C_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(C_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_uop;
        end
    end

endmodule

### hdl/msde_back.sv
// Back end: register file read, ALU, write-back, program counter and result register.
// Depends on msde_pkg; pops requests from msde_queue.
module msde_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  msde_pkg::t_uop      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_next_pc,
    output logic                o_write_enable,
    output logic [4:0]          o_dest_register,
    output logic signed [31:0]  o_write_value,
    output logic                o_illegal
);
    import msde_pkg::*;

    // Register file storage with per-entry valid bits (reset reads as zero)
    logic [C_WORD_W-1:0]    r_mem [C_NUM_REGS];
    logic [C_NUM_REGS-1:0]  r_reg_vld;

    // Read stage
    logic                   r_rd_vld;
    t_uop                   r_uop;
    logic [C_WORD_W-1:0]    r_mem_a, r_mem_b;
    logic                   r_a_ok, r_b_ok;
    logic                   r_fwd_en;
    logic [C_REG_IDX_W-1:0] r_fwd_idx;
    logic [C_WORD_W-1:0]    r_fwd_val;

    // Program counter and result register
    logic [C_WORD_W-1:0]    r_pc, n_pc;
    logic                   r_out_vld;
    logic [C_WORD_W-1:0]    r_next_pc;
    logic                   r_we;
    logic [C_REG_IDX_W-1:0] r_dest;
    logic [C_WORD_W-1:0]    r_value;
    logic                   r_ill;

    logic                   exec_fire;
    logic                   load;
    logic [C_WORD_W-1:0]    opnd_a, opnd_b, opnd_b2, alu_res, wr_val;
    logic                   is_ill;
    logic [C_REG_IDX_W-1:0] wr_dest;
    logic                   wr_en;

    // Handshake between stages
    assign exec_fire = r_rd_vld && (!r_out_vld || i_out_ready);
    assign load      = !i_empty && (!r_rd_vld || exec_fire);
    assign o_pop     = load;

    // Select operands: forward the write made when the read was taken
    always_comb begin
        if (r_fwd_en && r_fwd_idx == r_uop.rs) begin
            opnd_a = r_fwd_val;
        end else begin
            opnd_a = r_a_ok ? r_mem_a : '0;
        end
        if (r_fwd_en && r_fwd_idx == r_uop.rt) begin
            opnd_b = r_fwd_val;
        end else begin
            opnd_b = r_b_ok ? r_mem_b : '0;
        end
        opnd_b2 = r_uop.use_imm ? r_uop.imm : opnd_b;
    end

    // Execute one operation
    always_comb begin
        is_ill = 1'b0;
        unique case (r_uop.op)
            C_OP_SLL: alu_res = opnd_b << r_uop.shamt;
            C_OP_SRA: alu_res = C_WORD_W'($signed(opnd_b) >>> r_uop.shamt);
            C_OP_ADD: alu_res = opnd_a + opnd_b2;
            C_OP_SUB: alu_res = opnd_a - opnd_b2;
            C_OP_AND: alu_res = opnd_a & opnd_b2;
            C_OP_OR:  alu_res = opnd_a | opnd_b2;
            C_OP_NOR: alu_res = ~(opnd_a | opnd_b2);
            default: begin
                alu_res = '0;
                is_ill  = 1'b1;
            end
        endcase
        wr_val  = is_ill ? '0 : alu_res;
        wr_dest = is_ill ? '0 : r_uop.dest;
        wr_en   = exec_fire && !is_ill && (r_uop.dest != '0);
        n_pc    = r_pc + C_PC_STEP;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= '0;
            r_reg_vld <= '0;
            r_fwd_en  <= 1'b0;
        end else begin
            if (load) begin
                r_rd_vld <= 1'b1;
                r_fwd_en <= wr_en;
            end else if (exec_fire) begin
                r_rd_vld <= 1'b0;
            end
            if (exec_fire) begin
                r_out_vld <= 1'b1;
                r_pc      <= n_pc;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_reg_vld[r_uop.dest] <= 1'b1;
            end
        end
    end

    // Register file write and registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_uop.dest] <= alu_res;
        end
        if (load) begin
            r_uop     <= i_head;
            r_mem_a   <= r_mem[i_head.rs];
            r_mem_b   <= r_mem[i_head.rt];
            r_a_ok    <= r_reg_vld[i_head.rs] && (i_head.rs != '0);
            r_b_ok    <= r_reg_vld[i_head.rt] && (i_head.rt != '0);
            r_fwd_idx <= r_uop.dest;
            r_fwd_val <= alu_res;
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_next_pc <= n_pc;
            r_we      <= !is_ill;
            r_dest    <= wr_dest;
            r_value   <= wr_val;
            r_ill     <= is_ill;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_next_pc       = r_next_pc;
    assign o_write_enable  = r_we;
    assign o_dest_register = r_dest;
    assign o_write_value   = $signed(r_value);
    assign o_illegal       = r_ill;

endmodule
